// File: hdl/msu_pkg.sv
// Package for the Metropolis site update block: sizes, codes, payload structs,
// controller/datapath command types and the acceptance table.
// No dependencies.
package msu_pkg;

  localparam int SITES     = 64;
  localparam int SITE_W    = 6;
  localparam int MAX_GROUP = 64;
  localparam int GRP_W     = 7;
  localparam int VAL_W     = 16;
  localparam int EXP_DEPTH = 256;
  localparam int EXP_IDX_W = 8;
  localparam int DIV_W     = 54;
  localparam int DIV_CNT_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  typedef enum logic [1:0] {
    CMD_WRITE_VALUE = 2'd0,
    CMD_WRITE_EDGE  = 2'd1,
    CMD_WRITE_GROUP = 2'd2,
    CMD_UPDATE      = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUARTIC = 2'd0,
    CFG_BETA    = 2'd1,
    CFG_COARSE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [SITE_W-1:0]       site;
    logic [SITE_W-1:0]       neighbour;
    logic signed [VAL_W-1:0] load_value;
    logic [15:0]             proposal_random;
    logic [15:0]             accept_random;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] site_value;
    logic                    accepted;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_DISPATCH, S_OFF_GO, S_OFF_WAIT, S_OFF_TAKE, S_SUM,
    S_E1, S_E2, S_E3, S_E4, S_POT_GO, S_POT_WAIT, S_POT_TAKE, S_SP, S_DELTA,
    S_PROD1, S_PROD2, S_DECIDE, S_DONE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_DISPATCH, OP_OFF_GO, OP_OFF_TAKE, OP_SUM,
    OP_E1, OP_E2, OP_E3, OP_E4, OP_POT_GO, OP_POT_TAKE, OP_SP, OP_DELTA,
    OP_PROD1, OP_PROD2, OP_DECIDE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_new;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic n_zero;
    logic idx_last;
    logic div_busy;
  } dp_stat_t;

  typedef logic [16:0] exp_tab_t [EXP_DEPTH];

  // Long division of non-negative values below 2^32, used only while the table is built.
  function automatic longint udiv_small(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 31; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (longint'(1) <<< b);
      end
    end
    return quo;
  endfunction

  // exp(-16k/depth) in Q.16, from a series for exp(-y) raised to the 16th power.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    longint   y;
    longint   term;
    longint   acc;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      y    = longint'(k) <<< (30 - EXP_IDX_W);
      term = longint'(1) <<< 30;
      acc  = term;
      for (int i = 1; i <= 20; i++) begin
        term = udiv_small((term * y) >>> 30, longint'(i));
        if (i[0]) acc = acc - term;
        else acc = acc + term;
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
      for (int i = 0; i < 4; i++) acc = (acc * acc) >>> 30;
      tab[k] = 17'((acc * 65536 + (longint'(1) <<< 29)) >>> 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// File: hdl/metropolis_site_update_top.sv
// Metropolis site update, top level. A load command, or an update on an empty group,
// goes straight from dispatch to its result strobe; an update first runs three divider
// passes of 54 steps each and the 64-site neighbour sweep. One command at a time; busy
// stays high until the result cycle is over, so no new transfer is taken before then.
// After reset all 64 sites of the memories are cleared while busy is high; no stall.
module metropolis_site_update_top
  import msu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  msu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (dp_cmd),
    .stat_i         (dp_stat)
  );

  msu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .item_i     (item_i),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

// File: hdl/msu_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on msu_pkg.
module msu_div
  import msu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [GRP_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [GRP_W:0]       rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [GRP_W:0]       rem_sh;
  logic                 fits;

  assign rem_sh = {rem_q[GRP_W-1:0], quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      quo_d = {quo_q[DIV_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/msu_dp.sv
// Datapath: configuration registers, site/adjacency/group memories, energy
// arithmetic and the acceptance decision. Depends on msu_pkg and msu_div.
module msu_dp
  import msu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  item_t                item_i,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [15:0] lambda_q, beta_q;
  logic        coarse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= 16'd256;
      beta_q   <= 16'd256;
      coarse_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_QUARTIC: lambda_q <= cfg_data_i;
        CFG_BETA:    beta_q   <= cfg_data_i;
        CFG_COARSE:  coarse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Item and sweep index
  item_t             item_q;
  logic [SITE_W-1:0] idx_q;
  cmd_e              cmd;

  assign cmd = cmd_e'(item_q.command);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.op == OP_LATCH) begin
      idx_q <= '0;
    end else if (cmd_i.op == OP_CLEAR || cmd_i.op == OP_SUM) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Memories
  logic signed [VAL_W-1:0] sv_mem [SITES];
  logic [SITES-1:0]        adj_mem [SITES];
  logic [GRP_W-1:0]        grp_mem [SITES];

  logic signed [VAL_W-1:0] sv_rd;
  logic [SITES-1:0]        adj_rd;
  logic [GRP_W-1:0]        grp_rd;
  logic [SITE_W-1:0]       sv_raddr;

  logic                    sv_we, adj_we, grp_we;
  logic [SITE_W-1:0]       waddr;
  logic signed [VAL_W-1:0] sv_wdata;
  logic [SITES-1:0]        adj_wdata;
  logic [GRP_W-1:0]        grp_wdata;
  logic                    acc;
  logic signed [VAL_W-1:0] pn_q;

  assign sv_raddr = (cmd_i.op == OP_SUM) ? idx_q : item_q.site;

  always_comb begin
    adj_wdata                  = adj_rd;
    adj_wdata[item_q.neighbour] = item_q.load_value[0];
    if (item_q.load_value[VAL_W-1]) begin
      grp_wdata = '0;
    end else if (item_q.load_value > VAL_W'(MAX_GROUP)) begin
      grp_wdata = GRP_W'(MAX_GROUP);
    end else begin
      grp_wdata = item_q.load_value[GRP_W-1:0];
    end
    sv_we    = 1'b0;
    adj_we   = 1'b0;
    grp_we   = 1'b0;
    waddr    = item_q.site;
    sv_wdata = item_q.load_value;
    if (cmd_i.op == OP_CLEAR) begin
      sv_we     = 1'b1;
      adj_we    = 1'b1;
      grp_we    = 1'b1;
      waddr     = idx_q;
      sv_wdata  = '0;
      adj_wdata = '0;
      grp_wdata = '0;
    end else if (cmd_i.op == OP_DISPATCH) begin
      sv_we  = (cmd == CMD_WRITE_VALUE);
      adj_we = (cmd == CMD_WRITE_EDGE);
      grp_we = (cmd == CMD_WRITE_GROUP);
    end else if (cmd_i.op == OP_DECIDE) begin
      sv_we    = acc;
      sv_wdata = pn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_we) sv_mem[waddr] <= sv_wdata;
    sv_rd <= sv_mem[sv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[waddr] <= adj_wdata;
    adj_rd <= adj_mem[item_q.site];
  end

  always_ff @(posedge clk_i) begin
    if (grp_we) grp_mem[waddr] <= grp_wdata;
    grp_rd <= grp_mem[item_q.site];
  end

  // Dispatch
  logic [GRP_W-1:0]        n_eff, n_q;
  logic signed [VAL_W-1:0] p_q;
  result_t                 res_q;

  assign n_eff = coarse_q ? grp_rd : GRP_W'(1);

  // Proposal offset, floor((3u - 1.5) * 2048)
  logic [17:0] pr3;
  logic [13:0] off;
  logic        off_neg;
  logic [13:0] off_mag;

  assign pr3     = {2'b0, item_q.proposal_random} + {1'b0, item_q.proposal_random, 1'b0};
  assign off     = {1'b0, pr3[17:5]} - 14'd3072;
  assign off_neg = off[13];
  assign off_mag = off_neg ? (~off + 14'd1) : off;

  // Divider
  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [53:0]      m_q;

  assign div_start    = (cmd_i.op == OP_OFF_GO) || (cmd_i.op == OP_POT_GO);
  assign div_dividend = (cmd_i.op == OP_OFF_GO) ? DIV_W'(off_mag) : m_q;

  msu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // New value with saturation; truncation toward zero comes from dividing the magnitude.
  logic signed [17:0] step, pn_w;
  logic signed [VAL_W-1:0] pn_sat;

  assign step = off_neg ? -$signed({6'b0, div_quo[11:0]}) : $signed({6'b0, div_quo[11:0]});
  assign pn_w = {{2{p_q[VAL_W-1]}}, p_q} + step;

  always_comb begin
    if (!pn_w[17] && pn_w[16:15] != 2'b00) begin
      pn_sat = 16'sh7FFF;
    end else if (pn_w[17] && pn_w[16:15] != 2'b11) begin
      pn_sat = -16'sh8000;
    end else begin
      pn_sat = pn_w[15:0];
    end
  end

  // Neighbour sum, one site per cycle behind the registered read
  logic               sum_vld_q;
  logic [SITE_W-1:0]  sum_idx_q;
  logic signed [21:0] s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= (cmd_i.op == OP_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_idx_q <= idx_q;
    if (cmd_i.op == OP_LATCH) begin
      s_q <= '0;
    end else if (sum_vld_q && adj_rd[sum_idx_q]) begin
      s_q <= s_q + {{6{sv_rd[VAL_W-1]}}, sv_rd};
    end
  end

  // Quartic energy term, one selected value at a time
  logic signed [VAL_W-1:0] psel;
  logic signed [31:0]      sq;
  logic [19:0]             qv;
  logic signed [20:0]      d_q;
  logic signed [41:0]      d2_full;
  logic [37:0]             d2_q;
  logic [34:0]             mlo, mlo_q, mhi;
  logic [53:0]             pot_o_q, pot_n_q;

  assign psel    = cmd_i.sel_new ? pn_q : p_q;
  assign sq      = psel * psel;
  assign qv      = sq[30:11];
  assign d2_full = d_q * d_q;
  assign mlo     = lambda_q * d2_q[18:0];
  assign mhi     = lambda_q * d2_q[37:19];

  // Energy difference and acceptance
  logic signed [16:0] pdiff;
  logic signed [38:0] sp_full, sp_q;
  logic [56:0]        delta_q;
  logic [36:0]        pl, pl_q, ph;
  logic [57:0]        prod_q;
  logic               d_le0, d_small, p_small;
  logic [EXP_IDX_W-1:0] k;

  assign pdiff   = {pn_q[VAL_W-1], pn_q} - {p_q[VAL_W-1], p_q};
  assign sp_full = s_q * pdiff;
  assign pl      = beta_q * delta_q[20:0];
  assign ph      = beta_q * delta_q[41:21];
  assign d_le0   = delta_q[56] || (delta_q == '0);
  assign d_small = (delta_q[56:42] == '0);
  assign p_small = (prod_q[57:42] == '0);
  assign k       = prod_q[41:34];
  assign acc     = d_le0 ||
                   (d_small && p_small && ({1'b0, item_q.accept_random} < EXP_TAB[k]));

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_DISPATCH: begin
        n_q <= n_eff;
        p_q <= sv_rd;
        res_q.accepted   <= 1'b0;
        res_q.site_value <= (cmd == CMD_WRITE_VALUE) ? item_q.load_value : sv_rd;
      end
      OP_OFF_TAKE: pn_q <= pn_sat;
      OP_E1:       d_q  <= $signed({1'b0, qv}) - $signed({3'b0, n_q, 11'b0});
      OP_E2:       d2_q <= d2_full[37:0];
      OP_E3:       mlo_q <= mlo;
      OP_E4:       m_q  <= {mhi, 19'b0} + {19'b0, mlo_q};
      OP_POT_TAKE: begin
        if (cmd_i.sel_new) pot_n_q <= div_quo;
        else pot_o_q <= div_quo;
      end
      OP_SP:       sp_q <= sp_full;
      OP_DELTA:    delta_q <= {3'b0, pot_n_q} - {3'b0, pot_o_q} -
                              {{10{sp_q[38]}}, sp_q, 8'b0};
      OP_PROD1:    pl_q <= pl;
      OP_PROD2:    prod_q <= {ph, 21'b0} + {21'b0, pl_q};
      OP_DECIDE: begin
        res_q.accepted   <= acc;
        res_q.site_value <= acc ? pn_q : p_q;
      end
      default: ;
    endcase
  end

  assign stat_o.command  = cmd;
  assign stat_o.n_zero   = (n_eff == '0);
  assign stat_o.idx_last = (idx_q == SITE_W'(SITES - 1));
  assign stat_o.div_busy = div_busy;
  assign result_o        = res_q;

endmodule

// File: hdl/msu_ctrl.sv
// Controller state machine: sequences the datapath through clearing, loads
// and the update steps. Depends on msu_pkg.
module msu_ctrl
  import msu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     result_valid_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;
  logic        sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      S_CLEAR:    if (stat_i.idx_last) state_d = S_IDLE;
      S_IDLE:     if (start) state_d = S_READ;
      S_READ:     state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (stat_i.command == CMD_UPDATE && !stat_i.n_zero) state_d = S_OFF_GO;
        else state_d = S_DONE;
      end
      S_OFF_GO:   state_d = S_OFF_WAIT;
      S_OFF_WAIT: if (!stat_i.div_busy) state_d = S_OFF_TAKE;
      S_OFF_TAKE: begin
        state_d = S_SUM;
        sel_d   = 1'b0;
      end
      S_SUM:      if (stat_i.idx_last) state_d = S_E1;
      S_E1:       state_d = S_E2;
      S_E2:       state_d = S_E3;
      S_E3:       state_d = S_E4;
      S_E4:       state_d = S_POT_GO;
      S_POT_GO:   state_d = S_POT_WAIT;
      S_POT_WAIT: if (!stat_i.div_busy) state_d = S_POT_TAKE;
      S_POT_TAKE: begin
        // Old value's energy first, then the proposed one.
        sel_d   = !sel_q;
        state_d = sel_q ? S_SP : S_E1;
      end
      S_SP:       state_d = S_DELTA;
      S_DELTA:    state_d = S_PROD1;
      S_PROD1:    state_d = S_PROD2;
      S_PROD2:    state_d = S_DECIDE;
      S_DECIDE:   state_d = S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.sel_new  = sel_q;
    busy           = (state_q != S_IDLE);
    result_valid_o = (state_q == S_DONE);
    case (state_q)
      S_CLEAR:    cmd_o.op = OP_CLEAR;
      S_IDLE:     cmd_o.op = start ? OP_LATCH : OP_NONE;
      S_DISPATCH: cmd_o.op = OP_DISPATCH;
      S_OFF_GO:   cmd_o.op = OP_OFF_GO;
      S_OFF_TAKE: cmd_o.op = OP_OFF_TAKE;
      S_SUM:      cmd_o.op = OP_SUM;
      S_E1:       cmd_o.op = OP_E1;
      S_E2:       cmd_o.op = OP_E2;
      S_E3:       cmd_o.op = OP_E3;
      S_E4:       cmd_o.op = OP_E4;
      S_POT_GO:   cmd_o.op = OP_POT_GO;
      S_POT_TAKE: cmd_o.op = OP_POT_TAKE;
      S_SP:       cmd_o.op = OP_SP;
      S_DELTA:    cmd_o.op = OP_DELTA;
      S_PROD1:    cmd_o.op = OP_PROD1;
      S_PROD2:    cmd_o.op = OP_PROD2;
      S_DECIDE:   cmd_o.op = OP_DECIDE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule
